// ----- design/pstk_pkg.sv -----
// Shared types and constants for the persistent stack with snapshot slots.
// Used by the controller, the datapath and the top level. No dependencies.
package pstk_pkg;

    // Node pool and snapshot slot table sizes.
    localparam int POOL_NODES  = 1024;
    localparam int SLOT_COUNT  = 1024;

    // Node index width, and pointer width with room for the null code.
    localparam int IDX_W       = $clog2(POOL_NODES);
    localparam int PTR_W       = $clog2(POOL_NODES + 1);
    localparam int SLOT_IDX_W  = $clog2(SLOT_COUNT);

    // Field widths fixed by the interface.
    localparam int VALUE_W     = 32;
    localparam int SLOT_W      = 10;

    // A pointer equal to the pool size means the empty stack.
    localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(POOL_NODES);

    // Operation codes.
    typedef enum logic [1:0] {
        FUNC_PUSH = 2'd0,
        FUNC_POP  = 2'd1,
        FUNC_SAVE = 2'd2,
        FUNC_LOAD = 2'd3
    } t_func;

    // One input transaction.
    typedef struct packed {
        t_func               func;
        logic [VALUE_W-1:0]  value;
        logic [SLOT_W-1:0]   slot;
    } t_in_item;

    // One result transaction.
    typedef struct packed {
        logic                empty_res;
        logic [VALUE_W-1:0]  top;
        logic                overflow;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_wr;    // write null into the slot under the clear counter
        logic accept;    // latch the input item and issue the pointer reads
        logic exec;      // apply the operation with pointer read data
        logic val_upd;   // capture the value read for the new top
        logic load_out;  // load the result register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;  // clear counter at the last slot
        logic need_val;  // the new top must be read from the value store
        logic out_free;  // the result register can take a new result
    } t_status;

    // True when a pointer names a node.
    function automatic logic ptr_ok(input logic [PTR_W-1:0] p);
        return (32'(p) < POOL_NODES);
    endfunction

endpackage

// ----- design/persistent_stack_with_snapshots.sv -----
// Top level of the persistent stack with snapshot slots.
// Instantiates pstk_ctrl and pstk_dpath; depends on pstk_pkg.
//
// Each input transaction is one operation (push, pop, save, load) and gives
// one result describing the version current afterward. After reset the block
// clears all 1024 slots of the slot table and holds o_in_stall high until
// done. For push, save, and a pop or load that leaves the stack empty, an
// accepted transaction passes through S_PTR and then S_FIN, where the result
// register is loaded. A pop or load that reaches a node also passes through
// S_VAL between them, since it needs two dependent reads of synchronous memories
// (parent or slot table, then the node value store). One operation is in
// flight at a time; a finished result waits in an output register while the
// next transaction is accepted, and a result still held there stalls the
// following operation in its last step until it is taken.
module persistent_stack_with_snapshots (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pstk_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pstk_pkg::t_out_item o_out_data
);
    import pstk_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Control sequencing.
    pstk_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // Storage and result path.
    pstk_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- design/pstk_ctrl.sv -----
// Controller state machine for the persistent stack.
// Depends on pstk_pkg for the command and status structs.
module pstk_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  pstk_pkg::t_status i_status,
    output pstk_pkg::t_cmd    o_cmd,
    output logic              o_in_stall
);
    import pstk_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_PTR   = 5'b00100,
        S_VAL   = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_PTR;
                end
            end
            S_PTR: begin
                n_state = i_status.need_val ? S_VAL : S_FIN;
            end
            S_VAL: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Commands decoded from the state.
    always_comb begin
        o_cmd.clr_wr   = (r_state == S_CLEAR);
        o_cmd.accept   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.exec     = (r_state == S_PTR);
        o_cmd.val_upd  = (r_state == S_VAL);
        o_cmd.load_out = (r_state == S_FIN) && i_status.out_free;
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ----- design/pstk_dpath.sv -----
// Datapath for the persistent stack: node stores, slot table, top pointer,
// cached top value and the result register. Depends on pstk_pkg.
module pstk_dpath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pstk_pkg::t_cmd      i_cmd,
    input  pstk_pkg::t_in_item  i_in_data,
    input  logic                i_out_stall,
    output pstk_pkg::t_status   o_status,
    output logic                o_out_valid,
    output pstk_pkg::t_out_item o_out_data
);
    import pstk_pkg::*;

    // Memories.
    logic [VALUE_W-1:0] value_mem  [POOL_NODES];
    logic [PTR_W-1:0]   parent_mem [POOL_NODES];
    logic [PTR_W-1:0]   slot_mem   [SLOT_COUNT];

    // Latched operation.
    t_func              r_op;
    logic [VALUE_W-1:0] r_value;
    logic [SLOT_W-1:0]  r_slot;

    // Read data registers.
    logic [PTR_W-1:0]   r_par_rd;
    logic [PTR_W-1:0]   r_slot_rd;
    logic [VALUE_W-1:0] r_val_rd;

    // Stack state.
    logic [PTR_W-1:0]   r_top;
    logic [PTR_W-1:0]   r_next_free;
    logic [PTR_W-1:0]   n_top;
    logic               r_empty;
    logic [VALUE_W-1:0] r_top_val;
    logic               r_ovf;
    logic [SLOT_IDX_W-1:0] r_clr_idx;

    // Result register.
    logic               r_out_valid;
    t_out_item          r_out;

    logic slot_ok;
    logic push_ok;
    logic top_is_node;

    assign slot_ok     = (32'(r_slot) < SLOT_COUNT);
    assign push_ok     = ptr_ok(r_next_free);
    assign top_is_node = ptr_ok(r_top);

    // New top for pop and load, from the pointer read data.
    always_comb begin
        case (r_op)
            FUNC_POP:  n_top = top_is_node ? r_par_rd : NULL_PTR;
            FUNC_LOAD: n_top = slot_ok ? r_slot_rd : NULL_PTR;
            default:   n_top = r_top;
        endcase
    end

    // Input latch.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op    <= i_in_data.func;
            r_value <= i_in_data.value;
            r_slot  <= i_in_data.slot;
        end
    end

    // Node value store: written by push, read for the new top.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && (r_op == FUNC_PUSH) && push_ok) begin
            value_mem[r_next_free[IDX_W-1:0]] <= r_value;
        end
        if (i_cmd.exec) begin
            r_val_rd <= value_mem[n_top[IDX_W-1:0]];
        end
    end

    // Parent store: written by push, read at the current top on accept.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && (r_op == FUNC_PUSH) && push_ok) begin
            parent_mem[r_next_free[IDX_W-1:0]] <= r_top;
        end
        if (i_cmd.accept) begin
            r_par_rd <= parent_mem[r_top[IDX_W-1:0]];
        end
    end

    // Slot table: cleared after reset, written by save, read on accept.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            slot_mem[r_clr_idx] <= NULL_PTR;
        end else if (i_cmd.exec && (r_op == FUNC_SAVE) && slot_ok) begin
            slot_mem[r_slot[SLOT_IDX_W-1:0]] <= r_top;
        end
        if (i_cmd.accept) begin
            r_slot_rd <= slot_mem[i_in_data.slot[SLOT_IDX_W-1:0]];
        end
    end

    // Clear counter for the slot table pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_idx <= r_clr_idx + 1'b1;
        end
    end

    // Stack state update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top       <= NULL_PTR;
            r_next_free <= '0;
            r_empty     <= 1'b1;
            r_top_val   <= '0;
            r_ovf       <= 1'b0;
        end else if (i_cmd.exec) begin
            r_ovf <= (r_op == FUNC_PUSH) && !push_ok;
            case (r_op) inside
                FUNC_PUSH: begin
                    if (push_ok) begin
                        r_top       <= r_next_free;
                        r_next_free <= r_next_free + 1'b1;
                        r_empty     <= 1'b0;
                        r_top_val   <= r_value;
                    end
                end
                FUNC_POP, FUNC_LOAD: begin
                    r_top   <= n_top;
                    r_empty <= !ptr_ok(n_top);
                    if (!ptr_ok(n_top)) begin
                        r_top_val <= '0;
                    end
                end
                default: begin
                end
            endcase
        end else if (i_cmd.val_upd) begin
            r_top_val <= r_val_rd;
        end
    end

    // Result register; valid clears when the transaction is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.empty_res <= r_empty;
            r_out.top       <= r_top_val;
            r_out.overflow  <= r_ovf;
        end
    end

    // Status to the controller.
    always_comb begin
        o_status.clr_last = (r_clr_idx == SLOT_IDX_W'(SLOT_COUNT - 1));
        o_status.need_val = ((r_op == FUNC_POP) || (r_op == FUNC_LOAD)) && ptr_ok(n_top);
        o_status.out_free = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
